[rtl/tlpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_pkg: shared definitions for the three-level priority queue
// Command and status codes, register constants, default parameter values and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tlpq_pkg;

	// fixed field widths
	localparam int VALUE_W = 32;
	localparam int PRI_W   = 2;
	localparam int STAT_W  = 2;
	localparam int CAP_W   = 4;

	// default parameter values
	localparam int DEPTH_DEF      = 8;
	localparam int VALUE_BITS_DEF = 32;
	localparam int LEVELS_DEF     = 3;

	// capacity register reset value
	localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

	// operation codes
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BAD_PRI = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic push;
		logic pop;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
	} dp_stat_t;

endpackage

[rtl/three_level_priority_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_priority_queue_unit: strict-priority queue over three levels
// Enqueue appends to the FIFO of its level; dequeue pops the oldest value of
// the highest non-empty level. One total count is held against a capacity.
// ----------------------------------------------------------------------------
// usage: a command is taken at each rising edge where start is high and busy
// is low; busy stays low, so one command can be issued every cycle. each
// command gives exactly one result in the next cycle: done is high for that
// single cycle, with status, out_value, full_flag and empty_flag valid; the
// receiver cannot stall, so it must capture the result in that cycle. the
// rate is one command per cycle, set by the single-port store (one write or
// one registered read per cycle) and the pointer update. rejected
// commands (full, empty, bad priority) change no state. the capacity register
// resets to 8 and is written through cfg_valid/cfg_ready (ready is always
// high); write it only when no result is outstanding. capacity above the per-
// level depth acts as the depth; capacity zero keeps the queue always full.
// ----------------------------------------------------------------------------
module three_level_priority_queue_unit #(
	parameter int DEPTH      = tlpq_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = tlpq_pkg::VALUE_BITS_DEF,
	parameter int LEVELS     = tlpq_pkg::LEVELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// command channel
	input  logic                         start,
	output logic                         busy,
	input  logic                         cmd,
	input  logic [tlpq_pkg::VALUE_W-1:0] value,
	input  logic [tlpq_pkg::PRI_W-1:0]   priority_req,
	// result channel
	output logic                         done,
	output logic [tlpq_pkg::STAT_W-1:0]  status,
	output logic [tlpq_pkg::VALUE_W-1:0] out_value,
	output logic                         full_flag,
	output logic                         empty_flag,
	// capacity register write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tlpq_pkg::CAP_W-1:0]   cfg_data
);
	import tlpq_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;
	logic     cfg_we;

	// capacity transfer
	assign cfg_we = cfg_valid && cfg_ready;

	// controller: checks the command, drives push/pop and the result strobe
	tlpq_ctrl #(
		.LEVELS(LEVELS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.priority_req(priority_req),
		.stat_i      (dp_stat),
		.cmd_o       (dp_cmd),
		.busy        (busy),
		.cfg_ready   (cfg_ready),
		.done        (done),
		.status      (status)
	);

	// datapath: store, head/tail pointers, counts, capacity and flags
	tlpq_datapath #(
		.DEPTH     (DEPTH),
		.VALUE_BITS(VALUE_BITS),
		.LEVELS    (LEVELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_i       (dp_cmd),
		.value       (value),
		.priority_req(priority_req),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.stat_o      (dp_stat),
		.out_value   (out_value),
		.full_flag   (full_flag),
		.empty_flag  (empty_flag)
	);

endmodule

[rtl/tlpq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_datapath: level stores, pointers, counts and capacity register
// One memory holds all levels; push writes the tail of the requested level,
// pop reads the head of the highest non-empty level into a read register.
// ----------------------------------------------------------------------------
module tlpq_datapath #(
	parameter int DEPTH      = tlpq_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = tlpq_pkg::VALUE_BITS_DEF,
	parameter int LEVELS     = tlpq_pkg::LEVELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tlpq_pkg::dp_cmd_t            cmd_i,
	input  logic [tlpq_pkg::VALUE_W-1:0] value,
	input  logic [tlpq_pkg::PRI_W-1:0]   priority_req,
	input  logic                         cfg_we,
	input  logic [tlpq_pkg::CAP_W-1:0]   cfg_data,
	output tlpq_pkg::dp_stat_t           stat_o,
	output logic [tlpq_pkg::VALUE_W-1:0] out_value,
	output logic                         full_flag,
	output logic                         empty_flag
);
	import tlpq_pkg::*;

	localparam int SW   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int LW   = $clog2(LEVELS);
	localparam int NENT = LEVELS * DEPTH;
	localparam int AW   = $clog2(NENT);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	logic [SW-1:0]    mem [NENT];
	logic [SW-1:0]    rdata_q;
	logic             pop_ok_q;
	logic [IW-1:0]    head_q  [LEVELS];
	logic [IW-1:0]    tail_q  [LEVELS];
	logic [CW-1:0]    count_q [LEVELS];
	logic [CW-1:0]    total_q;
	logic [CAP_W-1:0] capacity_q;

	logic [LW-1:0]    enq_lv;
	logic [LW-1:0]    deq_lv;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	logic [CMPW-1:0]  cap_ext;
	logic [CMPW-1:0]  eff_cap;
	logic             full;
	logic [63:0]      rdata_ext;

	assign enq_lv = LW'({1'b0, priority_req} - 3'd1);

	// highest non-empty level wins
	always_comb begin
		deq_lv = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (count_q[l] != '0) begin
				deq_lv = LW'(l);
			end
		end
	end

	assign waddr = AW'(32'(enq_lv) * DEPTH + 32'(tail_q[enq_lv]));
	assign raddr = AW'(32'(deq_lv) * DEPTH + 32'(head_q[deq_lv]));

	assign cap_ext = CMPW'(capacity_q);
	assign eff_cap = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
	assign full    = CMPW'(total_q) >= eff_cap;

	assign stat_o.empty = (total_q == '0);
	assign stat_o.full  = full;
	assign full_flag    = full;
	assign empty_flag   = (total_q == '0);

	assign rdata_ext = 64'(rdata_q);
	assign out_value = pop_ok_q ? rdata_ext[VALUE_W-1:0] : '0;

	// store
	always_ff @(posedge clk) begin
		if (cmd_i.push) begin
			mem[waddr] <= value[SW-1:0];
		end
		if (cmd_i.pop) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_ok_q <= 1'b0;
			total_q  <= '0;
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
				count_q[l] <= '0;
			end
		end else begin
			pop_ok_q <= cmd_i.pop;
			if (cmd_i.push) begin
				tail_q[enq_lv]  <= (tail_q[enq_lv] == IW'(DEPTH - 1)) ? '0 : tail_q[enq_lv] + 1'b1;
				count_q[enq_lv] <= count_q[enq_lv] + 1'b1;
				total_q         <= total_q + 1'b1;
			end else if (cmd_i.pop) begin
				head_q[deq_lv]  <= (head_q[deq_lv] == IW'(DEPTH - 1)) ? '0 : head_q[deq_lv] + 1'b1;
				count_q[deq_lv] <= count_q[deq_lv] - 1'b1;
				total_q         <= total_q - 1'b1;
			end
		end
	end

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.push |-> !full)
		else $error("push issued while full");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.pop |-> (count_q[deq_lv] != '0))
		else $error("pop selected an empty level");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.push |=> total_q == CW'($past(total_q) + 1'b1))
		else $error("total count did not grow on push");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.pop && !cmd_i.push |=> total_q == CW'($past(total_q) - 1'b1))
		else $error("total count did not shrink on pop");

endmodule

[rtl/tlpq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_ctrl: command controller
// Checks each command against the datapath status, issues push or pop and
// holds the status code for the one-cycle result strobe.
// ----------------------------------------------------------------------------
module tlpq_ctrl #(
	parameter int LEVELS = tlpq_pkg::LEVELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        cmd,
	input  logic [tlpq_pkg::PRI_W-1:0]  priority_req,
	input  tlpq_pkg::dp_stat_t          stat_i,
	output tlpq_pkg::dp_cmd_t           cmd_o,
	output logic                        busy,
	output logic                        cfg_ready,
	output logic                        done,
	output logic [tlpq_pkg::STAT_W-1:0] status
);
	import tlpq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DONE = 1'b1;

	logic              state_q;
	logic              state_d;
	logic [STAT_W-1:0] status_q;
	logic [STAT_W-1:0] status_d;
	logic              accept;
	logic              pri_bad;

	// busy is never raised, so every command is taken when start is high
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign pri_bad   = (priority_req == '0) || (32'(priority_req) > LEVELS);

	always_comb begin
		status_d = STAT_OK;
		if (cmd == CMD_ENQ) begin
			if (pri_bad) begin
				status_d = STAT_BAD_PRI;
			end else if (stat_i.full) begin
				status_d = STAT_FULL;
			end
		end else if (stat_i.empty) begin
			status_d = STAT_EMPTY;
		end
	end

	assign cmd_o.push = accept && (cmd == CMD_ENQ) && (status_d == STAT_OK);
	assign cmd_o.pop  = accept && (cmd == CMD_DEQ) && (status_d == STAT_OK);

	always_comb begin
		unique case (state_q)
			S_IDLE:  state_d = accept ? S_DONE : S_IDLE;
			S_DONE:  state_d = accept ? S_DONE : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= STAT_OK;
		end else begin
			state_q <= state_d;
			if (accept) begin
				status_q <= status_d;
			end
		end
	end

	assign done   = (state_q == S_DONE);
	assign status = status_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted command produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without accepted command");

	a_bad_pri_enq: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == CMD_DEQ) |=> (status == STAT_OK) || (status == STAT_EMPTY))
		else $error("dequeue reported an enqueue-only status");

endmodule
